// File: rtl/core/fmo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmo_pkg
// Shared types, constants and table builders for the FM sine oscillator.
// ----------------------------------------------------------------------------
package fmo_pkg;

  localparam int SINE_ENTRIES = 1024;
  localparam int SINE_AW      = $clog2(SINE_ENTRIES);
  localparam int EXP_ENTRIES  = 256;
  localparam int EXP_AW       = $clog2(EXP_ENTRIES);

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] LN2_Q30     = 64'd744261118;

  // configuration register indexes
  localparam logic [1:0] REG_C4_STEP     = 2'd0;
  localparam logic [1:0] REG_SECOND_STEP = 2'd1;
  localparam logic [1:0] REG_MOD_AMOUNT  = 2'd2;

  localparam logic [29:0] C4_STEP_RESET     = 30'd25474809;
  localparam logic [31:0] SECOND_STEP_RESET = 32'd97391;
  localparam logic [13:0] MOD_AMOUNT_RESET  = 14'd0;

  localparam logic signed [16:0] PITCH_MAX = 17'sd16384;
  localparam logic signed [16:0] PITCH_MIN = -17'sd16384;

  typedef logic signed [31:0] sine_tab_t [SINE_ENTRIES];
  typedef logic [31:0]        exp_tab_t  [EXP_ENTRIES + 1];

  typedef struct packed {
    logic [29:0] c4_step;
    logic [31:0] second_step;
    logic [13:0] mod_amount;
  } cfg_t;

  // classified pitch: octave 0..8, exp table position and remainder
  typedef struct packed {
    logic [3:0]        oct;
    logic [EXP_AW-1:0] eidx;
    logic [11:0]       rem;
  } cmd_t;

  function automatic logic [63:0] quarter_sin(input logic [63:0] x);
    logic [63:0] t;
    logic signed [63:0] sum;
    t   = x;
    sum = $signed(x);
    for (int n = 1; n <= 12; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - $signed(t);
      else            sum = sum + $signed(t);
    end
    if (sum < 0) sum = 0;
    if (sum > $signed(Q30_ONE)) sum = $signed(Q30_ONE);
    return sum;
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    logic [63:0] x;
    logic [63:0] v;
    logic neg;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      x   = (TWO_PI_Q30 * 64'(k)) / SINE_ENTRIES;
      neg = 1'b0;
      if (x >= PI_Q30) begin
        neg = 1'b1;
        x   = x - PI_Q30;
      end
      if (x > HALF_PI_Q30) x = (x < PI_Q30) ? PI_Q30 - x : 64'd0;
      v = quarter_sin(x);
      tab[k] = neg ? -$signed(v[31:0]) : $signed(v[31:0]);
    end
    return tab;
  endfunction

  function automatic exp_tab_t build_exp();
    exp_tab_t tab;
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] sum;
    for (int k = 0; k <= EXP_ENTRIES; k++) begin
      y   = (LN2_Q30 * 64'(k)) / EXP_ENTRIES;
      t   = Q30_ONE;
      sum = Q30_ONE;
      for (int n = 1; n <= 20; n++) begin
        t   = ((t * y) >> 30) / 64'(n);
        sum = sum + t;
      end
      tab[k] = sum[31:0];
    end
    return tab;
  endfunction

endpackage

// File: rtl/core/fmo_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmo_if
// Valid/ready channels carrying pitch words in and audio words out.
// ----------------------------------------------------------------------------
interface fmo_pitch_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pitch_cv;
  modport source (output valid, output pitch_cv, input ready);
  modport sink (input valid, input pitch_cv, output ready);
endinterface

interface fmo_audio_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] audio_out;
  logic               blink_on;
  modport source (output valid, output audio_out, output blink_on, input ready);
  modport sink (input valid, input audio_out, input blink_on, output ready);
endinterface

// File: rtl/core/fm_sine_oscillator_voct.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fm_sine_oscillator_voct
// V/oct FM sine oscillator: pitch word in, audio sample and blink out.
// ----------------------------------------------------------------------------
// Usage:
//   pitch_in carries one signed pitch word (1/4096 V per LSB) per sample.
//   audio returns one word per pitch word: a signed 16-bit sample and the
//   one-second blink flag. Both channels are valid/ready.
//   Registers are written through wr_en/wr_index/wr_data while idle;
//   index 0 is the C4 phase step, 1 the blink step, 2 the FM amount.
// Timing:
//   The sequencer takes each word from queue pop to a loaded output
//   register through the exp2 step (one exp ROM port), three sine lookups
//   through the single sine ROM port, and set-up and mix.
//   It finishes one word before it pops the next one from the queue.
//   A two-word queue takes pitch words while the sequencer is busy.
// Reset: phases clear, registers take their defaults, the queue empties.
// When the receiver stalls, the result holds and the sequencer waits to
// load the next one; the queue fills and then drops ready.
// ----------------------------------------------------------------------------
module fm_sine_oscillator_voct (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data,
  fmo_pitch_if.sink   pitch_in,
  fmo_audio_if.source audio
);
  import fmo_pkg::*;

  cfg_t cfg;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.c4_step     <= C4_STEP_RESET;
      cfg.second_step <= SECOND_STEP_RESET;
      cfg.mod_amount  <= MOD_AMOUNT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_C4_STEP:     cfg.c4_step     <= wr_data[29:0];
        REG_SECOND_STEP: cfg.second_step <= wr_data;
        REG_MOD_AMOUNT:  cfg.mod_amount  <= wr_data[13:0];
        default: ;
      endcase
    end
  end

  fmo_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pitch_in  (pitch_in),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  fmo_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .audio     (audio)
  );

endmodule

// File: rtl/core/fmo_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmo_front
// Accepts pitch words, clamps and splits them, and queues them (2 deep).
// ----------------------------------------------------------------------------
module fmo_front (
  input  logic          clk,
  input  logic          rst,
  fmo_pitch_if.sink     pitch_in,
  output logic          cmd_valid,
  output fmo_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import fmo_pkg::*;

  logic signed [16:0] clamped;
  logic [15:0]        off;
  logic [11:0]        f;
  logic [EXP_AW+11:0] pos;
  cmd_t               cmd_in;
  cmd_t               queue [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               push;

  always_comb begin
    clamped = 17'(pitch_in.pitch_cv);
    if (clamped > PITCH_MAX) clamped = PITCH_MAX;
    if (clamped < PITCH_MIN) clamped = PITCH_MIN;
    off         = 16'(clamped + 17'sd16384);
    f           = off[11:0];
    pos         = {f, {EXP_AW{1'b0}}};
    cmd_in.oct  = off[15:12];
    cmd_in.eidx = pos[EXP_AW+11:12];
    cmd_in.rem  = pos[11:0];
  end

  assign pitch_in.ready = (count != 2'd2);
  assign push           = pitch_in.valid && pitch_in.ready;
  assign cmd_valid      = (count != 2'd0);
  assign cmd            = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= cmd_in;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

// File: rtl/core/fmo_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmo_back
// Sequencer: exp2 step, three shared sine lookups, mix, saturate, blink.
// ----------------------------------------------------------------------------
module fmo_back (
  input  logic          clk,
  input  logic          rst,
  input  fmo_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  input  fmo_pkg::cmd_t cmd,
  output logic          cmd_pop,
  fmo_audio_if.source   audio
);
  import fmo_pkg::*;

  localparam sine_tab_t SINE_ROM = build_sine();
  localparam exp_tab_t  EXP_ROM  = build_exp();

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_EXP0  = 4'd1;
  localparam logic [3:0] ST_EXP1  = 4'd2;
  localparam logic [3:0] ST_EXP2  = 4'd3;
  localparam logic [3:0] ST_EXP3  = 4'd4;
  localparam logic [3:0] ST_EXP4  = 4'd5;
  localparam logic [3:0] ST_MANG  = 4'd6;
  localparam logic [3:0] ST_L0    = 4'd7;
  localparam logic [3:0] ST_L1    = 4'd8;
  localparam logic [3:0] ST_L2    = 4'd9;
  localparam logic [3:0] ST_L3    = 4'd10;
  localparam logic [3:0] ST_L4    = 4'd11;
  localparam logic [3:0] ST_TMUL  = 4'd12;
  localparam logic [3:0] ST_TANG  = 4'd13;
  localparam logic [3:0] ST_OUT   = 4'd14;

  localparam logic [1:0] SEL_MOD  = 2'd0;
  localparam logic [1:0] SEL_TONE = 2'd1;
  localparam logic [1:0] SEL_CAR  = 2'd2;

  logic [3:0]          state;
  logic [1:0]          sel;
  cmd_t                cur;
  logic [31:0]         osc_phase;
  logic [31:0]         blink_phase;
  logic signed [31:0]  ph;
  logic signed [46:0]  mp;
  logic [31:0]         ea;
  logic [31:0]         ediff;
  logic [31:0]         e;
  logic [61:0]         stp;
  logic [31:0]         step_sh;
  logic [31:0]         ang;
  logic [SINE_AW-1:0]  s_addr;
  logic [EXP_AW:0]     e_addr;
  logic signed [31:0]  s_q;
  logic [31:0]         e_q;
  logic signed [31:0]  sa;
  logic signed [32:0]  sd;
  logic signed [49:0]  ip;
  logic signed [49:0]  ip_adj;
  logic signed [31:0]  res;
  logic signed [31:0]  cm;
  logic signed [31:0]  tone;
  logic signed [63:0]  tp;
  logic signed [32:0]  mix;
  logic signed [16:0]  mix_hi;
  logic signed [15:0]  sat;
  logic                out_free;

  always_comb begin
    s_addr = ang[31 -: SINE_AW];
    if (state == ST_L1) s_addr = ang[31 -: SINE_AW] + SINE_AW'(1);
    e_addr = {1'b0, cur.eidx};
    if (state == ST_EXP1) e_addr = {1'b0, cur.eidx} + (EXP_AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    s_q <= SINE_ROM[s_addr];
    e_q <= EXP_ROM[e_addr];
  end

  always_comb begin
    step_sh = (cur.oct >= 4'd4) ? (stp[61:30] << (cur.oct - 4'd4))
                                : (stp[61:30] >> (4'd4 - cur.oct));
    // interpolation term rounds toward zero
    ip_adj  = ip[49] ? (ip + 50'sd65535) >>> 16 : ip >>> 16;
    mix     = 33'(tone) + 33'(res);
    mix_hi  = 17'(mix >>> 16);
    if (mix_hi > 17'sd32767)       sat = 16'sh7fff;
    else if (mix_hi < -17'sd32768) sat = -16'sh8000;
    else                           sat = 16'(mix_hi);
  end

  assign out_free = !audio.valid || audio.ready;
  assign cmd_pop  = (state == ST_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur <= cmd;
        ph  <= $signed(osc_phase);
        mp  <= $signed({1'b0, cfg.mod_amount}) * $signed(osc_phase);
      end
      ST_EXP1: ea    <= e_q;
      ST_EXP2: ediff <= e_q - ea;
      ST_EXP3: e     <= ea + 32'((44'(ediff) * 44'(cur.rem)) >> 12);
      ST_EXP4: stp   <= 62'(cfg.c4_step) * 62'(e);
      ST_MANG: ang   <= mp[41:10];
      ST_L1:   sa    <= s_q;
      ST_L2:   sd    <= 33'(s_q) - 33'(sa);
      ST_L3:   ip    <= sd * $signed({1'b0, ang[31-SINE_AW -: 16]});
      ST_L4: begin
        res <= sa + 32'(ip_adj);
        if (sel == SEL_MOD)  cm <= sa + 32'(ip_adj);
        if (sel == SEL_TONE) begin
          tone <= sa + 32'(ip_adj);
          ang  <= osc_phase;
        end
      end
      ST_TMUL: tp  <= cm * ph;
      ST_TANG: ang <= 32'(ph * 32'sd300) + tp[61:30];
      default: ;
    endcase
    if (state == ST_OUT && out_free) begin
      audio.audio_out <= sat;
      audio.blink_on  <= ~(blink_phase + cfg.second_step) >> 31 == 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      sel         <= SEL_MOD;
      osc_phase   <= '0;
      blink_phase <= '0;
      audio.valid <= 1'b0;
    end else begin
      if (audio.valid && audio.ready && !(state == ST_OUT && out_free))
        audio.valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (cmd_valid) state <= ST_EXP0;
        ST_EXP0: state <= ST_EXP1;
        ST_EXP1: state <= ST_EXP2;
        ST_EXP2: state <= ST_EXP3;
        ST_EXP3: state <= ST_EXP4;
        ST_EXP4: state <= ST_MANG;
        ST_MANG: begin
          osc_phase <= osc_phase + step_sh;
          sel       <= SEL_MOD;
          state     <= ST_L0;
        end
        ST_L0: state <= ST_L1;
        ST_L1: state <= ST_L2;
        ST_L2: state <= ST_L3;
        ST_L3: state <= ST_L4;
        ST_L4: begin
          unique case (sel)
            SEL_MOD:  state <= ST_TMUL;
            SEL_TONE: begin
              sel   <= SEL_CAR;
              state <= ST_L0;
            end
            default:  state <= ST_OUT;
          endcase
        end
        ST_TMUL: state <= ST_TANG;
        ST_TANG: begin
          sel   <= SEL_TONE;
          state <= ST_L0;
        end
        ST_OUT: begin
          if (out_free) begin
            blink_phase <= blink_phase + cfg.second_step;
            audio.valid <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/fmo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmo_props
// Port-level checks for the FM oscillator, bound to the top level.
// ----------------------------------------------------------------------------
module fmo_props (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] audio_out,
  input logic               blink_on
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(audio_out) && $stable(blink_on))
    else $error("output word changed while stalled");

  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind fm_sine_oscillator_voct fmo_props u_fmo_props (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pitch_in.ready),
  .out_valid (audio.valid),
  .out_ready (audio.ready),
  .audio_out (audio.audio_out),
  .blink_on  (audio.blink_on)
);
